// File: rtl/min_lcm_pair_from_sum_assert.svh
// ----------------------------------------------------------------------------
// min_lcm_pair_from_sum_assert.svh
// Assertion macros shared by the RTL of the minimum-LCM pair splitter.
// Defining ASSERT_OFF turns every assertion into an empty statement.
// ----------------------------------------------------------------------------
`ifndef MIN_LCM_PAIR_FROM_SUM_ASSERT_SVH
`define MIN_LCM_PAIR_FROM_SUM_ASSERT_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define MLPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mlps assertion failed");

// The expression must never be true outside reset.
`define MLPS_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mlps forbidden condition seen");

`else

`define MLPS_ASSERT(lbl, clk, rst_n, prop)
`define MLPS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: rtl/mlps_pkg.sv
// ----------------------------------------------------------------------------
// mlps_pkg
// Shared widths, types and states of the minimum-LCM pair splitter.
// ----------------------------------------------------------------------------
package mlps_pkg;

  // Width of the number and of both result parts.
  localparam int NUMBER_WIDTH = 32;
  // Width of the divider step counter.
  localparam int CNT_W = $clog2(NUMBER_WIDTH);

  typedef logic [NUMBER_WIDTH-1:0] num_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic start;
    num_t dividend;
    num_t divisor;
  } div_req_t;

  // Status and results of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
    num_t quotient;
    num_t remainder;
  } div_rsp_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_HOLD
  } state_t;

endpackage

// File: rtl/mlps_if.sv
// ----------------------------------------------------------------------------
// mlps_if
// Valid/ready channels of the minimum-LCM pair splitter: one for the input
// number and one for the result pair.
// ----------------------------------------------------------------------------
interface mlps_in_if import mlps_pkg::*; ();
  logic valid;
  logic ready;
  num_t number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface mlps_out_if import mlps_pkg::*; ();
  logic valid;
  logic ready;
  num_t part_a;
  num_t part_b;

  modport source (output valid, output part_a, output part_b, input ready);
  modport sink (input valid, input part_a, input part_b, output ready);
endinterface

// File: rtl/min_lcm_pair_from_sum.sv
// ----------------------------------------------------------------------------
// min_lcm_pair_from_sum
// Splits a number n into a + b = n with minimum lcm(a, b): a is the largest
// proper divisor of n found by trial division, or 1 when n has none, and
// b = n - a.
//
//   Channel   Direction  Word
//   in_chan   input      number
//   out_chan  output     part_a, part_b
//
// Each trial divisor costs one pass through ST_START and ST_WAIT, in which the
// shared divider runs one division, so the time an item takes grows with d, the
// last divisor tried. Numbers below four skip the divider and go to ST_HOLD.
// in_ready is high only while the sequencer is idle. A finished pair waits in
// the output register while the next number is already being worked on; a
// second finished pair waits until the first is taken.
// Reset is synchronous, active low, and clears the sequencer and valid flags.
// ----------------------------------------------------------------------------
`include "min_lcm_pair_from_sum_assert.svh"

module min_lcm_pair_from_sum import mlps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mlps_in_if.sink           in_chan,
  mlps_out_if.source        out_chan
);

  state_t   state_r, state_nxt;
  num_t     n_r;
  num_t     d_r;
  num_t     a_r;
  logic     out_valid_r;
  num_t     out_a_r;
  num_t     out_b_r;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     in_take;
  logic     small_n;
  logic     out_free;
  logic     load_out;
  logic     hit_end;
  logic     hit_div;

  // Shared divider.
  mlps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Decisions taken on the current inputs and divider results.
  always_comb begin
    in_take  = in_chan.valid && (state_r == ST_IDLE);
    small_n  = (in_chan.number < NUMBER_WIDTH'(4));
    out_free = !out_valid_r || out_chan.ready;
    hit_end  = div_rsp.done && (d_r > div_rsp.quotient);
    hit_div  = div_rsp.done && (div_rsp.remainder == '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = small_n ? ST_HOLD : ST_START;
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        priority if (hit_end || hit_div) state_nxt = ST_HOLD;
        else if (div_rsp.done)           state_nxt = ST_START;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_chan.ready    = (state_r == ST_IDLE);
    div_req.start    = (state_r == ST_START);
    div_req.dividend = n_r;
    div_req.divisor  = d_r;
    load_out         = (state_r == ST_HOLD) && out_free;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)           out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Number, trial divisor and found part.
  always_ff @(posedge clk) begin
    if (in_take) begin
      n_r <= in_chan.number;
      d_r <= NUMBER_WIDTH'(2);
      a_r <= NUMBER_WIDTH'(1);
    end else if (state_r == ST_WAIT && div_rsp.done) begin
      priority if (hit_end) a_r <= NUMBER_WIDTH'(1);
      else if (hit_div)     a_r <= div_rsp.quotient;
      else                  d_r <= d_r + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_a_r <= a_r;
      out_b_r <= n_r - a_r;
    end
  end

  always_comb begin
    out_chan.valid  = out_valid_r;
    out_chan.part_a = out_a_r;
    out_chan.part_b = out_b_r;
  end

  // The two parts of a loaded word always add back to the number.
  `MLPS_ASSERT(a_top_sum, clk, rst_n,
    load_out |=> ((out_a_r + out_b_r) == $past(n_r)))
  // Trial divisors start at two and a division only runs while waiting.
  `MLPS_NEVER(a_top_div_low, clk, rst_n, (state_r == ST_WAIT) && (d_r < NUMBER_WIDTH'(2)))
  `MLPS_NEVER(a_top_div_idle, clk, rst_n, div_rsp.busy && (state_r != ST_WAIT))

endmodule

// File: rtl/mlps_div.sv
// ----------------------------------------------------------------------------
// mlps_div
// Shared restoring divider: one quotient bit per cycle, with a one-cycle done
// pulse at the end. A start is only taken while the divider is not busy.
// ----------------------------------------------------------------------------
`include "min_lcm_pair_from_sum_assert.svh"

module mlps_div import mlps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  cnt_t                    cnt_r, cnt_nxt;
  num_t                    rem_r, rem_nxt;
  num_t                    quo_r, quo_nxt;
  num_t                    dvs_r, dvs_nxt;
  logic [NUMBER_WIDTH:0]   trial;
  logic [NUMBER_WIDTH:0]   diff;
  logic                    fits;

  // One restoring step: shift the next dividend bit into the remainder and
  // subtract the divisor when it fits.
  always_comb begin
    trial = {rem_r, quo_r[NUMBER_WIDTH-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Next values of the divider registers.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUMBER_WIDTH - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
      quo_nxt = {quo_r[NUMBER_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    rsp.busy      = busy_r;
    rsp.done      = done_r;
    rsp.quotient  = quo_r;
    rsp.remainder = rem_r;
  end

  // A start is only issued to an idle divider, and it makes it busy.
  `MLPS_NEVER(a_div_start_busy, clk, rst_n, req.start && busy_r)
  `MLPS_ASSERT(a_div_start_runs, clk, rst_n, req.start |=> busy_r)
  // A finished division leaves a remainder below a nonzero divisor.
  `MLPS_ASSERT(a_div_rem_small, clk, rst_n,
    (done_r && (dvs_r != '0)) |-> (rem_r < dvs_r))

endmodule
